/* hw/rtl/vte_pkg.sv */
// Shared types and constants for the version triple extractor.
package vte_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam int unsigned NUM_W = 32;

    // Classified byte handed from the front end to the back end.
    typedef struct packed {
        logic       is_digit;
        logic       is_dot;
        logic [3:0] digit;
        logic       last;
    } cls_word_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_MAJOR  = 3'd1,
        PH_DOT1   = 3'd2,
        PH_MINOR  = 3'd3,
        PH_DOT2   = 3'd4,
        PH_PATCH  = 3'd5,
        PH_DONE   = 3'd6,
        PH_SKIP   = 3'd7
    } phase_t;

endpackage

/* hw/rtl/vte_front.sv */
// Input stage: register each byte and classify it for the back end.
module vte_front
    import vte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       push,
    output cls_word_t  push_word,
    input  fifo_stat_t fifo_stat
);

    logic      valid_reg;
    logic      valid_next;
    cls_word_t word_reg;
    cls_word_t word_next;
    logic      take;

    assign push     = valid_reg && !fifo_stat.full;
    assign in_ready = !valid_reg || !fifo_stat.full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        word_next          = word_reg;
        word_next.is_digit = ch inside {[CH_ZERO:CH_NINE]};
        word_next.is_dot   = (ch == CH_DOT);
        word_next.digit    = word_next.is_digit ? 4'(ch - CH_ZERO) : 4'd0;
        word_next.last     = last;
        valid_next         = take ? 1'b1 : (push ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset; load only on a new byte.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

    assign push_word = word_reg;

endmodule

/* hw/rtl/vte_fifo.sv */
// Short queue of classified bytes between front and back end.
module vte_fifo
    import vte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cls_word_t  push_word,
    input  logic       pop,
    output cls_word_t  head_word,
    output fifo_stat_t stat
);

    cls_word_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word  = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* hw/rtl/vte_back.sv */
// Back end: triple-matching state machine, accumulators and result register.
module vte_back
    import vte_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cls_word_t        head_word,
    input  fifo_stat_t       fifo_stat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             found,
    output logic [NUM_W-1:0] major_num,
    output logic [NUM_W-1:0] minor_num,
    output logic [NUM_W-1:0] patch_num
);

    phase_t           phase_reg;
    phase_t           phase_next;
    phase_t           step_phase;
    logic [NUM_W-1:0] major_reg;
    logic [NUM_W-1:0] major_next;
    logic [NUM_W-1:0] minor_reg;
    logic [NUM_W-1:0] minor_next;
    logic [NUM_W-1:0] patch_reg;
    logic [NUM_W-1:0] patch_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             found_reg;
    logic             found_next;
    logic [NUM_W-1:0] res_major_reg;
    logic [NUM_W-1:0] res_major_next;
    logic [NUM_W-1:0] res_minor_reg;
    logic [NUM_W-1:0] res_minor_next;
    logic [NUM_W-1:0] res_patch_reg;
    logic [NUM_W-1:0] res_patch_next;
    logic [NUM_W-1:0] acc_sel;
    logic [NUM_W+3:0] acc_prod;
    logic             acc_ovf;
    logic             ok;
    logic             load_result;

    // Advance on every queued byte; only a last byte waits for the result slot.
    assign pop         = !fifo_stat.empty &&
                         (!head_word.last || !out_valid_reg || out_ready);
    assign load_result = pop && head_word.last;

    // One shared multiply-by-ten and add for whichever number is running.
    always_comb
    begin
        case (phase_reg)
            PH_MAJOR: acc_sel = major_reg;
            PH_MINOR: acc_sel = minor_reg;
            PH_PATCH: acc_sel = patch_reg;
            default:  acc_sel = '0;
        endcase
        acc_prod = ((NUM_W+4)'(acc_sel) << 3) + ((NUM_W+4)'(acc_sel) << 1)
                 + (NUM_W+4)'(head_word.digit);
        acc_ovf  = |acc_prod[NUM_W+3:NUM_W];
    end

    // Next state.
    always_comb
    begin
        step_phase = phase_reg;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (head_word.is_digit)
                    step_phase = PH_MAJOR;
            end
            PH_MAJOR:
            begin
                if (head_word.is_digit)
                    step_phase = acc_ovf ? PH_SKIP : PH_MAJOR;
                else
                    step_phase = head_word.is_dot ? PH_DOT1 : PH_SEARCH;
            end
            PH_DOT1:
            begin
                step_phase = head_word.is_digit ? PH_MINOR : PH_SEARCH;
            end
            PH_MINOR:
            begin
                if (head_word.is_digit)
                    step_phase = acc_ovf ? PH_SKIP : PH_MINOR;
                else
                    step_phase = head_word.is_dot ? PH_DOT2 : PH_SEARCH;
            end
            PH_DOT2:
            begin
                step_phase = head_word.is_digit ? PH_PATCH : PH_SEARCH;
            end
            PH_PATCH:
            begin
                if (head_word.is_digit)
                    step_phase = acc_ovf ? PH_SKIP : PH_PATCH;
                else
                    step_phase = PH_DONE;
            end
            PH_DONE:
            begin
                step_phase = PH_DONE;
            end
            PH_SKIP:
            begin
                if (!head_word.is_digit)
                    step_phase = PH_SEARCH;
            end
            default:
            begin
                step_phase = PH_SEARCH;
            end
        endcase

        if (!pop)
            phase_next = phase_reg;
        else if (head_word.last)
            phase_next = PH_SEARCH;
        else
            phase_next = step_phase;
    end

    // Accumulators and result.
    always_comb
    begin
        major_next     = major_reg;
        minor_next     = minor_reg;
        patch_next     = patch_reg;
        ok             = (step_phase == PH_DONE) || (step_phase == PH_PATCH);
        found_next     = found_reg;
        res_major_next = res_major_reg;
        res_minor_next = res_minor_reg;
        res_patch_next = res_patch_reg;
        out_valid_next = out_valid_reg;

        if (pop && head_word.is_digit)
        begin
            case (phase_reg)
                PH_SEARCH: major_next = NUM_W'(head_word.digit);
                PH_DOT1:   minor_next = NUM_W'(head_word.digit);
                PH_DOT2:   patch_next = NUM_W'(head_word.digit);
                PH_MAJOR:  major_next = acc_ovf ? major_reg : acc_prod[NUM_W-1:0];
                PH_MINOR:  minor_next = acc_ovf ? minor_reg : acc_prod[NUM_W-1:0];
                PH_PATCH:  patch_next = acc_ovf ? patch_reg : acc_prod[NUM_W-1:0];
                default:   major_next = major_reg;
            endcase
        end

        if (load_result)
        begin
            found_next     = ok;
            res_major_next = ok ? major_next : '0;
            res_minor_next = ok ? minor_next : '0;
            res_patch_next = ok ? patch_next : '0;
            out_valid_next = 1'b1;
            major_next     = '0;
            minor_next     = '0;
            patch_next     = '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            major_reg     <= '0;
            minor_reg     <= '0;
            patch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            patch_reg     <= patch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg     <= found_next;
        res_major_reg <= res_major_next;
        res_minor_reg <= res_minor_next;
        res_patch_reg <= res_patch_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign major_num = res_major_reg;
    assign minor_num = res_minor_reg;
    assign patch_num = res_patch_reg;

endmodule

/* hw/rtl/version_triple_extractor_top.sv */
// Path: an accepted byte is held in the front-end register, then in the queue; popping
//   a last byte loads the result word, once the result register is free.
// Throughput: one byte per cycle through the single multiply-by-ten-and-add
//   in the back end; only a last byte waits on a stalled result register.
// Reset: rst_n clears the state machine, accumulators, queue and all valids.
// One result word per string, emitted on the byte flagged last.
module version_triple_extractor_top
    import vte_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       ch,
    input  logic             last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             found,
    output logic [NUM_W-1:0] major_num,
    output logic [NUM_W-1:0] minor_num,
    output logic [NUM_W-1:0] patch_num
);

    logic       push;
    cls_word_t  push_word;
    logic       pop;
    cls_word_t  head_word;
    fifo_stat_t fifo_stat;

    // Front end: register the incoming byte and classify it.
    vte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .push      (push),
        .push_word (push_word),
        .fifo_stat (fifo_stat)
    );

    // Queue: decouple classification from matching so each side stalls alone.
    vte_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .stat      (fifo_stat)
    );

    // Back end: match the triple, accumulate numbers, hold the result word.
    vte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_word (head_word),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .major_num (major_num),
        .minor_num (minor_num),
        .patch_num (patch_num)
    );

    // A word that did not find a triple carries all-zero numbers.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> major_num == '0 && minor_num == '0 && patch_num == '0)
        else $error("non-found result carries nonzero numbers");

    // The queue is never full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue status inconsistent");

    // Popping a last byte always loads a result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_word.last |=> out_valid)
        else $error("last byte consumed without a result word");

    // Nothing is popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule
